/* rtl/tncp_pkg.sv */
// ----------------------------------------------------------------------------
// tncp_pkg: shared definitions for the telnet command parser
// Telnet protocol bytes, option numbers, result kinds and the parse phases.
// ----------------------------------------------------------------------------
package tncp_pkg;

  localparam int MaskWidth     = 64;
  localparam int CfgIndexWidth = 1;

  localparam logic [7:0] TnIac  = 8'hFF;
  localparam logic [7:0] TnDont = 8'hFE;
  localparam logic [7:0] TnDo   = 8'hFD;
  localparam logic [7:0] TnWont = 8'hFC;
  localparam logic [7:0] TnWill = 8'hFB;
  localparam logic [7:0] TnSb   = 8'hFA;
  localparam logic [7:0] TnSe   = 8'hF0;

  localparam logic [7:0] OptWinsize = 8'd31;
  localparam logic [7:0] OptTtype   = 8'd24;

  localparam logic [MaskWidth-1:0] WillMaskReset = 64'd107;
  localparam logic [MaskWidth-1:0] DoMaskReset   = 64'd2164260875;

  localparam logic [CfgIndexWidth-1:0] CfgWillMask = 1'd0;
  localparam logic [CfgIndexWidth-1:0] CfgDoMask   = 1'd1;

  localparam logic [1:0] KindData  = 2'd0;
  localparam logic [1:0] KindReply = 2'd1;
  localparam logic [1:0] KindSize  = 2'd2;

  localparam logic [1:0] VerbWill = 2'd0;
  localparam logic [1:0] VerbDo   = 2'd2;

  typedef enum logic [7:0] {
    PH_DATA     = 8'b0000_0001,
    PH_IAC      = 8'b0000_0010,
    PH_VERB     = 8'b0000_0100,
    PH_SB_OPT   = 8'b0000_1000,
    PH_SIZE     = 8'b0001_0000,
    PH_SIZE_IAC = 8'b0010_0000,
    PH_SKIP     = 8'b0100_0000,
    PH_SKIP_IAC = 8'b1000_0000
  } phase_t;

endpackage

/* rtl/telnet_command_parser_top.sv */
// ----------------------------------------------------------------------------
// telnet_command_parser_top: receive-side telnet command parser
// A result and the next phase are both registered when the byte is accepted.
// Throughput: one byte per cycle while out_ready does not stall a waiting result.
// A byte is taken while a finished result still waits, if that result leaves.
// Reset clears the phase, pending verb, size count and the output valid, and
// loads both option-accept masks with their defaults.
// ----------------------------------------------------------------------------
module telnet_command_parser_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tncp_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [tncp_pkg::MaskWidth-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         rx_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         kind,
  output logic [7:0]                         data_byte,
  output logic [7:0]                         reply_cmd,
  output logic [7:0]                         reply_opt,
  output logic [15:0]                        win_width,
  output logic [15:0]                        win_height
);
  import tncp_pkg::*;

  logic [MaskWidth-1:0] accept_will_mask;
  logic [MaskWidth-1:0] accept_do_mask;
  phase_t               phase, phase_next;
  logic [1:0]           pending_verb, pending_verb_next;
  logic [2:0]           size_count, size_count_next;
  logic [7:0]           size_bytes [4];
  logic [7:0]           size_bytes_next [4];

  logic                 res_valid;
  logic [1:0]           res_kind;
  logic [7:0]           res_data;
  logic [7:0]           res_cmd;
  logic [7:0]           res_opt;
  logic                 in_fire;
  logic                 opt_in_range;

  assign in_ready     = !out_valid || out_ready;
  assign in_fire      = in_valid && in_ready;
  assign opt_in_range = (rx_byte[7:6] == 2'b00);

  always_comb begin
    phase_next        = phase;
    pending_verb_next = pending_verb;
    size_count_next   = size_count;
    size_bytes_next   = size_bytes;
    res_valid         = 1'b0;
    res_kind          = KindData;
    res_data          = 8'd0;
    res_cmd           = 8'd0;
    res_opt           = 8'd0;
    unique case (phase)
      PH_DATA: begin
        if (rx_byte == TnIac) begin
          phase_next = PH_IAC;
        end else begin
          res_valid = 1'b1;
          res_data  = rx_byte;
        end
      end
      PH_IAC: begin
        if (rx_byte == TnIac) begin
          phase_next = PH_DATA;
          res_valid  = 1'b1;
          res_data   = TnIac;
        end else if (rx_byte >= TnWill && rx_byte <= TnDont) begin
          pending_verb_next = 2'(rx_byte - TnWill);
          phase_next        = PH_VERB;
        end else if (rx_byte == TnSb) begin
          phase_next = PH_SB_OPT;
        end else begin
          phase_next = PH_DATA;
        end
      end
      PH_VERB: begin
        phase_next = PH_DATA;
        if (pending_verb == VerbWill) begin
          res_valid = 1'b1;
          res_kind  = KindReply;
          res_cmd   = (opt_in_range && accept_will_mask[rx_byte[5:0]]) ? TnDo : TnDont;
          res_opt   = rx_byte;
        end else if (pending_verb == VerbDo) begin
          res_valid = 1'b1;
          res_kind  = KindReply;
          res_cmd   = (opt_in_range && accept_do_mask[rx_byte[5:0]]) ? TnWill : TnWont;
          res_opt   = rx_byte;
        end
      end
      PH_SB_OPT: begin
        if (rx_byte == OptWinsize) begin
          size_count_next = 3'd0;
          phase_next      = PH_SIZE;
        end else if (rx_byte == TnIac) begin
          phase_next = PH_SKIP_IAC;
        end else begin
          phase_next = PH_SKIP;
        end
      end
      PH_SIZE: begin
        if (rx_byte == TnIac) begin
          phase_next = PH_SIZE_IAC;
        end else begin
          size_bytes_next[size_count_next[1:0]] = rx_byte;
          size_count_next = size_count_next + 3'd1;
          if (size_count_next >= 3'd4) begin
            res_valid  = 1'b1;
            res_kind   = KindSize;
            phase_next = PH_SKIP;
          end
        end
      end
      PH_SIZE_IAC: begin
        if (rx_byte == TnSe) begin
          phase_next = PH_DATA;
        end else begin
          // An IAC not followed by SE is kept as 0xFF; the byte after it is payload too
          // unless it is a second IAC or the 0xFF already completed the window size.
          phase_next = PH_SIZE;
          size_bytes_next[size_count_next[1:0]] = TnIac;
          size_count_next = size_count_next + 3'd1;
          if (size_count_next >= 3'd4) begin
            res_valid  = 1'b1;
            res_kind   = KindSize;
            phase_next = PH_SKIP;
          end else if (rx_byte != TnIac) begin
            size_bytes_next[size_count_next[1:0]] = rx_byte;
            size_count_next = size_count_next + 3'd1;
            if (size_count_next >= 3'd4) begin
              res_valid  = 1'b1;
              res_kind   = KindSize;
              phase_next = PH_SKIP;
            end
          end
        end
      end
      PH_SKIP: begin
        if (rx_byte == TnIac) begin
          phase_next = PH_SKIP_IAC;
        end
      end
      PH_SKIP_IAC: begin
        phase_next = (rx_byte == TnSe) ? PH_DATA : PH_SKIP;
      end
      default: begin
        phase_next = PH_DATA;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accept_will_mask <= WillMaskReset;
      accept_do_mask   <= DoMaskReset;
    end else if (cfg_we) begin
      if (cfg_index == CfgWillMask) begin
        accept_will_mask <= cfg_data;
      end else if (cfg_index == CfgDoMask) begin
        accept_do_mask <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_DATA;
      pending_verb <= 2'd0;
      size_count   <= 3'd0;
      out_valid    <= 1'b0;
    end else begin
      if (in_fire) begin
        phase        <= phase_next;
        pending_verb <= pending_verb_next;
        size_count   <= size_count_next;
        out_valid    <= res_valid;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      size_bytes <= size_bytes_next;
      if (res_valid) begin
        kind       <= res_kind;
        data_byte  <= res_data;
        reply_cmd  <= res_cmd;
        reply_opt  <= res_opt;
        win_width  <= (res_kind == KindSize) ?
                      {size_bytes_next[0], size_bytes_next[1]} : 16'd0;
        win_height <= (res_kind == KindSize) ?
                      {size_bytes_next[2], size_bytes_next[3]} : 16'd0;
      end
    end
  end

endmodule
